@@ hdl/m3i_pkg.sv @@
// Package for the 3x3 matrix inverse block.
// Holds the fixed widths, saturation constants and the task record passed
// from the front end through the queue to the divider back end.
package m3i_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned COF_W  = 65;
  localparam int unsigned MAG_W  = 64;
  localparam int unsigned DET_W  = 98;
  localparam int unsigned DMAG_W = 97;
  localparam int unsigned THR_W  = 31;
  localparam int unsigned N_ELEM = 9;

  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [N_ELEM-1:0][MAG_W-1:0] adj_mag;
    logic [N_ELEM-1:0]            adj_neg;
    logic [DMAG_W-1:0]            det_mag;
    logic                         det_neg;
    logic [ELEM_W-1:0]            det_value;
    logic                         sing;
  } task_t;

endpackage

@@ hdl/m3i_in_if.sv @@
// Input channel of the 3x3 matrix inverse block: one matrix per item.
// Depends on m3i_pkg for the element width.
interface m3i_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_00;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_01;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_02;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_10;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_11;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_12;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_20;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_21;
  logic signed [m3i_pkg::ELEM_W-1:0]    elem_22;

  modport source (
    output valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
           elem_20, elem_21, elem_22,
    input  ready
  );
  modport sink (
    input  valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
           elem_20, elem_21, elem_22,
    output ready
  );
endinterface

@@ hdl/m3i_out_if.sv @@
// Output channel of the 3x3 matrix inverse block: inverse, determinant, flag.
// Depends on m3i_pkg for the element width.
interface m3i_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_00;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_01;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_02;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_10;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_11;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_12;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_20;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_21;
  logic signed [m3i_pkg::ELEM_W-1:0]    inv_22;
  logic signed [m3i_pkg::ELEM_W-1:0]    det_value;
  logic                                 is_singular;

  modport source (
    output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
           inv_20, inv_21, inv_22, det_value, is_singular,
    input  ready
  );
  modport sink (
    input  valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
           inv_20, inv_21, inv_22, det_value, is_singular,
    output ready
  );
endinterface

@@ hdl/m3i_front.sv @@
// Front end: cofactors, determinant, rounding and singular classification.
// Seven-stage stall pipeline; depends on m3i_pkg and m3i_in_if.
module m3i_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  m3i_in_if.sink                       in_i,
  input  logic [m3i_pkg::THR_W-1:0]    thr_i,
  output m3i_pkg::task_t               task_o,
  output logic                         task_valid_o,
  input  logic                         task_ready_i
);

  localparam int unsigned EW = m3i_pkg::ELEM_W;
  localparam int unsigned CW = m3i_pkg::COF_W;
  localparam int unsigned DW = m3i_pkg::DET_W;
  localparam int unsigned MW = m3i_pkg::DMAG_W;
  localparam int unsigned NE = m3i_pkg::N_ELEM;
  localparam logic [DW-1:0] RND = DW'(1) << (2 * FRAC_BITS - 1);

  logic              en;
  logic [6:0]        vld_q;
  logic signed [EW-1:0] e [3][3];

  logic signed [2*EW-1:0] pa_q [NE];
  logic signed [2*EW-1:0] pb_q [NE];
  logic signed [EW-1:0]   e0_q [2][3];
  logic signed [CW-1:0]   cof_q [NE];
  logic signed [EW+33:0]  plo_q [3];
  logic signed [EW+32:0]  phi_q [3];
  logic [NE-1:0][m3i_pkg::MAG_W-1:0] mag_q [4];
  logic [NE-1:0]                     neg_q [4];
  logic signed [DW-1:0]   term_q [3];
  logic signed [DW-1:0]   det_q;
  logic signed [DW-1:0]   rnd_q;
  logic [MW-1:0]          dmag_q;
  logic                   dneg_q;
  m3i_pkg::task_t         task_q;

  logic [NE-1:0][CW-1:0]  cof_abs;
  logic [DW-1:0]          det_neg_val;
  logic signed [DW-1:0]   rnd_sh;
  logic [DW-EW:0]         rnd_hi;
  logic [MW-1:0]          thr_scaled;

  assign e[0][0] = in_i.elem_00;
  assign e[0][1] = in_i.elem_01;
  assign e[0][2] = in_i.elem_02;
  assign e[1][0] = in_i.elem_10;
  assign e[1][1] = in_i.elem_11;
  assign e[1][2] = in_i.elem_12;
  assign e[2][0] = in_i.elem_20;
  assign e[2][1] = in_i.elem_21;
  assign e[2][2] = in_i.elem_22;

  assign en           = !vld_q[6] || task_ready_i;
  assign in_i.ready   = en;
  assign task_valid_o = vld_q[6];
  assign task_o       = task_q;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      cof_abs[k] = cof_q[k][CW-1] ? (CW'(0) - cof_q[k]) : cof_q[k];
    end
  end

  assign det_neg_val = DW'(0) - det_q;
  assign rnd_sh      = rnd_q >>> (2 * FRAC_BITS);
  assign rnd_hi      = rnd_sh[DW-1:EW-1];
  assign thr_scaled  = MW'({thr_i, {(2 * FRAC_BITS){1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= e[1][1] * e[2][2];  pb_q[0] <= e[1][2] * e[2][1];
      pa_q[1] <= e[1][2] * e[2][0];  pb_q[1] <= e[1][0] * e[2][2];
      pa_q[2] <= e[1][0] * e[2][1];  pb_q[2] <= e[1][1] * e[2][0];
      pa_q[3] <= e[0][2] * e[2][1];  pb_q[3] <= e[0][1] * e[2][2];
      pa_q[4] <= e[0][0] * e[2][2];  pb_q[4] <= e[0][2] * e[2][0];
      pa_q[5] <= e[0][1] * e[2][0];  pb_q[5] <= e[0][0] * e[2][1];
      pa_q[6] <= e[0][1] * e[1][2];  pb_q[6] <= e[0][2] * e[1][1];
      pa_q[7] <= e[0][2] * e[1][0];  pb_q[7] <= e[0][0] * e[1][2];
      pa_q[8] <= e[0][0] * e[1][1];  pb_q[8] <= e[0][1] * e[1][0];
      for (int j = 0; j < 3; j++) begin
        e0_q[0][j] <= e[0][j];
        e0_q[1][j] <= e0_q[0][j];
      end

      for (int k = 0; k < NE; k++) begin
        cof_q[k] <= {pa_q[k][2*EW-1], pa_q[k]} - {pb_q[k][2*EW-1], pb_q[k]};
      end

      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= $signed({e0_q[1][j][EW-1], e0_q[1][j]}) *
                    $signed({1'b0, cof_q[j][EW-1:0]});
        phi_q[j] <= $signed(e0_q[1][j]) * $signed(cof_q[j][CW-1:EW]);
      end
      for (int k = 0; k < NE; k++) begin
        mag_q[0][k] <= cof_abs[k][m3i_pkg::MAG_W-1:0];
        neg_q[0][k] <= cof_q[k][CW-1];
      end
      for (int s = 1; s < 4; s++) begin
        mag_q[s] <= mag_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end

      for (int j = 0; j < 3; j++) begin
        term_q[j] <= {phi_q[j][EW+32], phi_q[j], {EW{1'b0}}} +
                     {{(DW-EW-34){plo_q[j][EW+33]}}, plo_q[j]};
      end

      det_q <= term_q[0] + term_q[1] + term_q[2];

      rnd_q  <= det_q + RND;
      dmag_q <= det_q[DW-1] ? det_neg_val[MW-1:0] : det_q[MW-1:0];
      dneg_q <= det_q[DW-1];

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          task_q.adj_mag[i*3+j] <= mag_q[3][j*3+i];
          task_q.adj_neg[i*3+j] <= neg_q[3][j*3+i];
        end
      end
      task_q.det_mag <= dmag_q;
      task_q.det_neg <= dneg_q;
      if ((&rnd_hi) || !(|rnd_hi)) begin
        task_q.det_value <= rnd_sh[EW-1:0];
      end else begin
        task_q.det_value <= rnd_sh[DW-1] ? m3i_pkg::SAT_NEG : m3i_pkg::SAT_POS;
      end
      task_q.sing <= (dmag_q == '0) || (dmag_q < thr_scaled);
    end
  end

endmodule

@@ hdl/m3i_queue.sv @@
// Short queue between front end and back end so that each side stalls alone.
// Register array with counters; depends on m3i_pkg for the task record.
module m3i_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  m3i_pkg::task_t   push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output m3i_pkg::task_t   pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  m3i_pkg::task_t  mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/m3i_div.sv @@
// Pipelined restoring divider for one inverse element, one quotient bit per
// stage, with an overflow flag for saturation. Depends on m3i_pkg.
module m3i_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [m3i_pkg::MAG_W-1:0]     mag_i,
  input  logic [m3i_pkg::DMAG_W-1:0]    det_mag_i,
  output logic [m3i_pkg::ELEM_W-1:0]    quo_o,
  output logic                          ovf_o
);

  localparam int unsigned QW = m3i_pkg::ELEM_W;
  localparam int unsigned ST = QW;
  localparam int unsigned DW = m3i_pkg::DMAG_W + 1;
  localparam int unsigned NW = 2 * FRAC_BITS + 99;

  logic [NW-1:0]  num;
  logic [DW-1:0]  den;
  logic           ovf0;

  logic [DW-1:0]  rem_q [ST+1];
  logic [DW-1:0]  den_q [ST+1];
  logic [QW-1:0]  lo_q  [ST+1];
  logic [QW-1:0]  quo_q [ST+1];
  logic           ovf_q [ST+1];

  logic [DW-1:0]  rem_nx [ST];
  logic [QW-1:0]  quo_nx [ST];

  assign num  = (NW'(mag_i) << (2 * FRAC_BITS + 1)) + NW'(det_mag_i);
  assign den  = {det_mag_i, 1'b0};
  assign ovf0 = (num >= (NW'(den) << QW));

  for (genvar k = 0; k < ST; k++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;
    assign r2         = {rem_q[k], lo_q[k][QW-1]};
    assign diff       = r2 - {1'b0, den_q[k]};
    assign ge         = (r2 >= {1'b0, den_q[k]});
    assign rem_nx[k]  = ge ? diff[DW-1:0] : r2[DW-1:0];
    assign quo_nx[k]  = {quo_q[k][QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(num >> QW);
      den_q[0] <= den;
      lo_q[0]  <= num[QW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf0;
      for (int k = 0; k < ST; k++) begin
        rem_q[k+1] <= rem_nx[k];
        den_q[k+1] <= den_q[k];
        lo_q[k+1]  <= {lo_q[k][QW-2:0], 1'b0};
        quo_q[k+1] <= quo_nx[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[ST];
  assign ovf_o = ovf_q[ST];

endmodule

@@ hdl/m3i_back.sv @@
// Back end: nine pipelined dividers, sign and saturation, output register.
// Depends on m3i_pkg, m3i_div and m3i_out_if.
module m3i_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  m3i_pkg::task_t   task_i,
  input  logic             task_valid_i,
  output logic             task_ready_o,
  m3i_out_if.source        out_o
);

  localparam int unsigned EW  = m3i_pkg::ELEM_W;
  localparam int unsigned NE  = m3i_pkg::N_ELEM;
  localparam int unsigned LAT = EW + 1;

  logic                 en;
  logic [LAT-1:0]       vld_q;
  logic [NE-1:0]        neg_q  [LAT];
  logic                 sing_q [LAT];
  logic [EW-1:0]        detv_q [LAT];
  logic [NE-1:0][EW-1:0] quo;
  logic [NE-1:0]        ovf;
  logic [NE-1:0][EW-1:0] inv_d;

  logic                 out_vld_q;
  logic [NE-1:0][EW-1:0] inv_q;
  logic [EW-1:0]        det_q;
  logic                 sing_out_q;

  assign en           = !out_vld_q || out_o.ready;
  assign task_ready_o = en;

  for (genvar k = 0; k < NE; k++) begin : g_div
    m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i     (clk_i),
      .en_i      (en),
      .mag_i     (task_i.adj_mag[k]),
      .det_mag_i (task_i.det_mag),
      .quo_o     (quo[k]),
      .ovf_o     (ovf[k])
    );
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (sing_q[LAT-1]) begin
        inv_d[k] = '0;
      end else if (neg_q[LAT-1][k]) begin
        inv_d[k] = (ovf[k] || (quo[k] > m3i_pkg::SAT_NEG)) ? m3i_pkg::SAT_NEG
                                                          : EW'(0) - quo[k];
      end else begin
        inv_d[k] = (ovf[k] || (quo[k] > m3i_pkg::SAT_POS)) ? m3i_pkg::SAT_POS : quo[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LAT-2:0], task_valid_i};
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0]  <= task_i.adj_neg ^ {NE{task_i.det_neg}};
      sing_q[0] <= task_i.sing;
      detv_q[0] <= task_i.det_value;
      for (int s = 1; s < LAT; s++) begin
        neg_q[s]  <= neg_q[s-1];
        sing_q[s] <= sing_q[s-1];
        detv_q[s] <= detv_q[s-1];
      end
      inv_q      <= inv_d;
      det_q      <= detv_q[LAT-1];
      sing_out_q <= sing_q[LAT-1];
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.inv_00      = inv_q[0];
  assign out_o.inv_01      = inv_q[1];
  assign out_o.inv_02      = inv_q[2];
  assign out_o.inv_10      = inv_q[3];
  assign out_o.inv_11      = inv_q[4];
  assign out_o.inv_12      = inv_q[5];
  assign out_o.inv_20      = inv_q[6];
  assign out_o.inv_21      = inv_q[7];
  assign out_o.inv_22      = inv_q[8];
  assign out_o.det_value   = det_q;
  assign out_o.is_singular = sing_out_q;

endmodule

@@ hdl/matrix3_inverse_top.sv @@
// Top level of the 3x3 fixed-point matrix inverse block.
// Depends on m3i_pkg, the channel interfaces, m3i_front, m3i_queue and m3i_back.
//
// The block accepts one matrix per clock cycle unless the output stalls it and
// returns one result per matrix, in order. A matrix passes through the 7
// front-end stages (cofactor products, cofactors, determinant partial products,
// terms, sum, rounding, classification), the queue, the nine pipelined
// restoring dividers that retire one quotient bit per stage, and the output
// register. The singular threshold is written through cfg_we_i and cfg_data_i;
// the user is to write it only while the block is idle (the block itself does
// not enforce this). It resets to one least significant bit.
module matrix3_inverse_top #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  m3i_in_if.sink                      in_i,
  m3i_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [m3i_pkg::THR_W-1:0]   cfg_data_i
);

  logic [m3i_pkg::THR_W-1:0] thr_q;
  m3i_pkg::task_t            f_task, b_task;
  logic                      f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= m3i_pkg::THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .thr_i        (thr_q),
    .task_o       (f_task),
    .task_valid_o (f_valid),
    .task_ready_i (f_ready)
  );

  m3i_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_task),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_data_o   (b_task),
    .pop_ready_i  (b_ready)
  );

  m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (b_task),
    .task_valid_i (b_valid),
    .task_ready_o (b_ready),
    .out_o        (out_o)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for matrix3_inverse_top: random and directed matrices.
// Depends on m3i_pkg and the channel interfaces; expected inverses are computed
// exactly in wide integer arithmetic and compared in order on the output channel.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [199:0] wide_t;

  typedef struct {
    int  inv [9];
    int  det;
    bit  sing;
  } inv_result_t;

  class inverse_scoreboard;
    inv_result_t                 pending_q [$];
    bit [m3i_pkg::THR_W-1:0]     threshold = 1;
    int                          errors = 0;

    function int sat32(wide_t v);
      if (v > wide_t'(32'sh7FFF_FFFF)) return int'(m3i_pkg::SAT_POS);
      if (v < -(wide_t'(1) <<< 31)) return int'(m3i_pkg::SAT_NEG);
      return int'(v[31:0]);
    endfunction

    function inv_result_t compute_inverse(input int m [9]);
      wide_t e [9];
      wide_t c [9];
      wide_t det, dmag, thr, adj, mag, q;
      inv_result_t r;
      for (int k = 0; k < 9; k++) e[k] = m[k];
      c[0] = e[4] * e[8] - e[5] * e[7];
      c[1] = e[5] * e[6] - e[3] * e[8];
      c[2] = e[3] * e[7] - e[4] * e[6];
      c[3] = e[2] * e[7] - e[1] * e[8];
      c[4] = e[0] * e[8] - e[2] * e[6];
      c[5] = e[1] * e[6] - e[0] * e[7];
      c[6] = e[1] * e[5] - e[2] * e[4];
      c[7] = e[2] * e[3] - e[0] * e[5];
      c[8] = e[0] * e[4] - e[1] * e[3];
      det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
      dmag = (det < 0) ? -det : det;
      r.det = sat32((det + (wide_t'(1) <<< 31)) >>> 32);
      thr = 0;
      thr[m3i_pkg::THR_W-1:0] = threshold;
      r.sing = (det == 0) || (dmag < (thr <<< 32));
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (r.sing) begin
            r.inv[i*3+j] = 0;
          end else begin
            adj = c[j*3+i];
            mag = (adj < 0) ? -adj : adj;
            q = ((mag <<< 33) + dmag) / (dmag <<< 1);
            if ((adj < 0) != (det < 0)) q = -q;
            r.inv[i*3+j] = sat32(q);
          end
        end
      end
      return r;
    endfunction

    function void note_matrix(input int m [9]);
      pending_q.push_back(compute_inverse(m));
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(inv_result_t got);
      inv_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.inv[k] !== want.inv[k])
          report($sformatf("inv_%0d%0d", k / 3, k % 3), got.inv[k], want.inv[k]);
      if (got.det !== want.det) report("det_value", got.det, want.det);
      if (got.sing !== want.sing) report("is_singular", int'(got.sing), int'(want.sing));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [m3i_pkg::THR_W-1:0] cfg_data_i = '0;
  bit idle_on = 1'b1;

  m3i_in_if  in_if ();
  m3i_out_if out_if ();

  matrix3_inverse_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  inverse_scoreboard sb = new();

  initial begin
    in_if.valid = 1'b0;
    {in_if.elem_00, in_if.elem_01, in_if.elem_02} = '0;
    {in_if.elem_10, in_if.elem_11, in_if.elem_12} = '0;
    {in_if.elem_20, in_if.elem_21, in_if.elem_22} = '0;
    out_if.ready = 1'b0;
  end

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function int draw_gap();
    return idle_on ? $urandom_range(0, 14) : 0;
  endfunction

  task send_matrix(input int m [9]);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.elem_00 <= m[0];
    in_if.elem_01 <= m[1];
    in_if.elem_02 <= m[2];
    in_if.elem_10 <= m[3];
    in_if.elem_11 <= m[4];
    in_if.elem_12 <= m[5];
    in_if.elem_20 <= m[6];
    in_if.elem_21 <= m[7];
    in_if.elem_22 <= m[8];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_matrix(m);
  endtask

  task drain_block();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task write_threshold(bit [m3i_pkg::THR_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.threshold = value;
  endtask

  function int pick_special();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return 65536;
      4: return -65536;
      5: return 32'sh7FFF_FFFF;
      6: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function int pick_small();
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  task send_random();
    int m [9];
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1, 2, 3: m[k] = pick_small();
        4, 5: m[k] = $urandom;
        6: m[k] = pick_special();
        7: m[k] = (k % 4 == 0) ? $urandom : (($urandom_range(0, 3) == 0) ? pick_small() : 0);
        default: m[k] = int'($urandom_range(0, 1 << 14)) - (1 << 13);
      endcase
    end
    if (kind >= 8) begin
      for (int k = 0; k < 3; k++) m[6+k] = m[k] + m[3+k];
      if (kind == 9) m[8] = m[8] + int'($urandom_range(0, 4)) - 2;
    end
    send_matrix(m);
  endtask

  task send_directed();
    int m [9];
    int one;
    one = 65536;
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};                     send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                           send_matrix(m);
    m = '{2*one, 0, 0, 0, 2*one, 0, 0, 0, 2*one};               send_matrix(m);
    m = '{one/2, 0, 0, 0, one/2, 0, 0, 0, one/2};               send_matrix(m);
    m = '{1, 0, 0, 0, one, 0, 0, 0, one};                       send_matrix(m);
    m = '{2, 0, 0, 0, one, 0, 0, 0, one};                       send_matrix(m);
    m = '{3, 0, 0, 0, one, 0, 0, 0, -one};                      send_matrix(m);
    m = '{32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF};
    send_matrix(m);
    m = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 32'sh7FFF_FFFF;         send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 32'sh8000_0000;         send_matrix(m);
    m = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0,
          32'sh8000_0000};
    send_matrix(m);
    m = '{0, one, 0, 0, 0, one, one, 0, 0};                     send_matrix(m);
    m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 10*one};
    send_matrix(m);
    m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
    send_matrix(m);
    m = '{-one, 0, 0, 0, 3*one, 0, 0, 0, 3*one};                send_matrix(m);
    m = '{one, 0, 0, 0, 1, 0, 0, 0, 1};                         send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};                  send_matrix(m);
  endtask

  initial begin
    forever begin
      int gap;
      inv_result_t got;
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && rst_ni));
      got.inv[0] = out_if.inv_00;
      got.inv[1] = out_if.inv_01;
      got.inv[2] = out_if.inv_02;
      got.inv[3] = out_if.inv_10;
      got.inv[4] = out_if.inv_11;
      got.inv[5] = out_if.inv_12;
      got.inv[6] = out_if.inv_20;
      got.inv[7] = out_if.inv_21;
      got.inv[8] = out_if.inv_22;
      got.det    = out_if.det_value;
      got.sing   = out_if.is_singular;
      sb.check_result(got);
    end
  end

  initial begin
    bit [m3i_pkg::THR_W-1:0] thresholds [6];
    thresholds = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd0, 31'd1};
    thresholds[4] = $urandom_range(0, 1 << 18);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_threshold(thresholds[p]);
      idle_on = (p != 3);
      send_directed();
      for (int n = 0; n < 230; n++) send_random();
      drain_block();
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
